### rtl/core/dmxdbt_pkg.sv
`timescale 1ns / 1ps
package dmxdbt_pkg;

  localparam logic [2:0] KIND_WRITE_OK  = 3'd0;
  localparam logic [2:0] KIND_WRITE_BAD = 3'd1;
  localparam logic [2:0] KIND_BREAK     = 3'd2;
  localparam logic [2:0] KIND_MAB       = 3'd3;
  localparam logic [2:0] KIND_SLOT      = 3'd4;

  localparam logic OP_WRITE   = 1'b0;
  localparam logic OP_ADVANCE = 1'b1;

  localparam logic [1:0] CFG_FRAME_SLOTS = 2'd0;
  localparam logic [1:0] CFG_BREAK_US    = 2'd1;
  localparam logic [1:0] CFG_MAB_US      = 2'd2;

  localparam logic [9:0] RST_FRAME_SLOTS = 10'd513;
  localparam logic [9:0] RST_BREAK_US    = 10'd184;
  localparam logic [9:0] RST_MAB_US      = 10'd24;

  localparam logic [9:0] BREAK_MIN_US = 10'd88;
  localparam logic [9:0] MAB_MIN_US   = 10'd8;
  localparam logic [9:0] DUR_MAX_US   = 10'd1000;

  localparam logic [7:0] NULL_START_BYTE = 8'h00;

  typedef struct packed {
    logic       valid;
    logic [2:0] kind;
    logic [9:0] duration_us;
    logic       last_slot;
    logic       use_mem;
  } stage_t;

  function automatic logic [9:0] clamp_dur(input logic [9:0] v, input logic [9:0] lo);
    logic [9:0] r;
    if (v < lo) begin
      r = lo;
    end else if (v > DUR_MAX_US) begin
      r = DUR_MAX_US;
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

### rtl/core/dmxdbt_bank_ram.sv
`timescale 1ns / 1ps
module dmxdbt_bank_ram #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [7:0]    wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [7:0]    rdata
);

  logic [7:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### rtl/core/dmxdbt_ctrl.sv
`timescale 1ns / 1ps
module dmxdbt_ctrl
  import dmxdbt_pkg::*;
#(
  parameter int CHANNELS = 512,
  parameter int AW       = 10,
  parameter int PW       = 10
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_stall,
  input  logic          opcode,
  input  logic [9:0]    channel,
  input  logic [7:0]    value,
  input  logic [9:0]    frame_slots,
  input  logic [9:0]    break_us,
  input  logic [9:0]    mark_after_break_us,
  input  logic          take,
  output stage_t        stage,
  output logic          ram_we,
  output logic [AW-1:0] ram_waddr,
  output logic [7:0]    ram_wdata,
  output logic          ram_re,
  output logic [AW-1:0] ram_raddr
);

  localparam int DEPTH = 2 * CHANNELS;
  localparam logic [AW-1:0] BANK_OFS = AW'(CHANNELS);
  localparam logic [9:0] SLOTS_MAX = 10'(CHANNELS + 1);

  logic          clearing;
  logic [AW-1:0] clr_addr;
  logic          front_bank;
  logic          swap_pending;
  logic [PW-1:0] pos;
  logic [PW-1:0] pos_next;

  logic          accept;
  logic          ch_ok;
  logic [PW-1:0] slots;
  logic          is_last;
  logic          slot_in_bank;
  logic [AW-1:0] wr_addr;
  logic [AW-1:0] rd_addr;
  stage_t        stage_next;

  assign in_stall = clearing || (stage.valid && !take);
  assign accept   = in_valid && !in_stall;
  assign ch_ok    = (channel >= 10'd1) && (channel <= 10'(CHANNELS));

  always_comb begin
    if (frame_slots == 10'd0) begin
      slots = PW'(1);
    end else if (frame_slots > SLOTS_MAX) begin
      slots = PW'(SLOTS_MAX);
    end else begin
      slots = PW'(frame_slots);
    end
  end

  assign is_last      = ({1'b0, pos} >= ({1'b0, slots} + 1'b1));
  assign slot_in_bank = (pos >= PW'(3)) && (pos <= PW'(CHANNELS + 2));
  assign wr_addr      = (front_bank ? '0 : BANK_OFS) + AW'(channel - 10'd1);
  assign rd_addr      = (front_bank ? BANK_OFS : '0) + AW'(pos - PW'(3));

  always_comb begin
    stage_next             = '0;
    stage_next.valid       = 1'b1;
    pos_next               = pos;
    if (opcode == OP_WRITE) begin
      stage_next.kind = ch_ok ? KIND_WRITE_OK : KIND_WRITE_BAD;
    end else if (pos == '0) begin
      stage_next.kind        = KIND_BREAK;
      stage_next.duration_us = clamp_dur(break_us, BREAK_MIN_US);
      pos_next               = PW'(1);
    end else if (pos == PW'(1)) begin
      stage_next.kind        = KIND_MAB;
      stage_next.duration_us = clamp_dur(mark_after_break_us, MAB_MIN_US);
      pos_next               = PW'(2);
    end else begin
      stage_next.kind      = KIND_SLOT;
      stage_next.last_slot = is_last;
      stage_next.use_mem   = slot_in_bank;
      pos_next             = is_last ? '0 : pos + 1'b1;
    end
  end

  always_comb begin
    if (clearing) begin
      ram_we    = 1'b1;
      ram_waddr = clr_addr;
      ram_wdata = 8'h00;
    end else begin
      ram_we    = accept && (opcode == OP_WRITE) && ch_ok;
      ram_waddr = wr_addr;
      ram_wdata = value;
    end
  end

  assign ram_re    = accept && (opcode == OP_ADVANCE) && (pos >= PW'(2)) && slot_in_bank;
  assign ram_raddr = rd_addr;

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing     <= 1'b1;
      clr_addr     <= '0;
      front_bank   <= 1'b0;
      swap_pending <= 1'b0;
      pos          <= '0;
      stage        <= '0;
    end else begin
      if (clearing) begin
        clr_addr <= clr_addr + 1'b1;
        if (clr_addr == AW'(DEPTH - 1)) begin
          clearing <= 1'b0;
        end
      end
      if (accept) begin
        stage <= stage_next;
        if (opcode == OP_WRITE) begin
          if (ch_ok) begin
            swap_pending <= 1'b1;
          end
        end else begin
          pos <= pos_next;
          if ((pos == '0) && swap_pending) begin
            front_bank   <= ~front_bank;
            swap_pending <= 1'b0;
          end
        end
      end else if (take) begin
        stage.valid <= 1'b0;
      end
    end
  end

endmodule

### rtl/core/dmx_double_buffered_transmitter.sv
`timescale 1ns / 1ps
// Channel   Handshake              Payload
// in        in_valid / in_stall    opcode, channel, value
// out       out_valid / out_stall  kind, data, duration_us, last_slot
// cfg       cfg_we                 cfg_index, cfg_data
//
// Each word gives one result word: decode and bank read fill the stage register,
// then the output register. Words are taken one per cycle while in_stall is low.
// After reset the bank memory is cleared one entry per cycle, all 2 * CHANNELS entries,
// with in_stall held high; configuration writes are taken during that pass.
// A stalled output holds its word while one more input word is taken and parked.
module dmx_double_buffered_transmitter
  import dmxdbt_pkg::*;
#(
  parameter int CHANNELS = 512
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       opcode,
  input  logic [9:0] channel,
  input  logic [7:0] value,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [2:0] kind,
  output logic [7:0] data,
  output logic [9:0] duration_us,
  output logic       last_slot,
  input  logic       cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [9:0] cfg_data
);

  localparam int DEPTH = 2 * CHANNELS;
  localparam int AW    = $clog2(DEPTH);
  localparam int PW    = $clog2(CHANNELS + 3);

  logic [9:0]    frame_slots;
  logic [9:0]    break_us;
  logic [9:0]    mark_after_break_us;
  stage_t        stage;
  logic          take;
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [7:0]    ram_wdata;
  logic          ram_re;
  logic [AW-1:0] ram_raddr;
  logic [7:0]    ram_rdata;

  assign take = stage.valid && (!out_valid || !out_stall);

  dmxdbt_ctrl #(
    .CHANNELS (CHANNELS),
    .AW       (AW),
    .PW       (PW)
  ) u_ctrl (
    .clk                 (clk),
    .rst                 (rst),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .opcode              (opcode),
    .channel             (channel),
    .value               (value),
    .frame_slots         (frame_slots),
    .break_us            (break_us),
    .mark_after_break_us (mark_after_break_us),
    .take                (take),
    .stage               (stage),
    .ram_we              (ram_we),
    .ram_waddr           (ram_waddr),
    .ram_wdata           (ram_wdata),
    .ram_re              (ram_re),
    .ram_raddr           (ram_raddr)
  );

  dmxdbt_bank_ram #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_slots         <= RST_FRAME_SLOTS;
      break_us            <= RST_BREAK_US;
      mark_after_break_us <= RST_MAB_US;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_FRAME_SLOTS: frame_slots         <= cfg_data;
        CFG_BREAK_US:    break_us            <= cfg_data;
        CFG_MAB_US:      mark_after_break_us <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (take) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      kind        <= stage.kind;
      data        <= stage.use_mem ? ram_rdata : NULL_START_BYTE;
      duration_us <= stage.duration_us;
      last_slot   <= stage.last_slot;
    end
  end

endmodule

### tb/tb_dmx_double_buffered_transmitter.sv
`timescale 1ns / 1ps
module tb_dmx_double_buffered_transmitter;
  import dmxdbt_pkg::*;

  localparam int CHANNELS = 512;
  localparam int CYCLE_LIMIT = 200000;
  localparam int PHASES = 8;
  localparam int WORDS_PER_PHASE = 80;
  localparam logic [1:0] CFG_UNUSED = 2'd3;
  localparam int POS_BREAK = 0;
  localparam int POS_MAB = 1;
  localparam int POS_FIRST_SLOT = 2;

  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] data;
    logic [9:0] dur;
    logic       last;
  } sym_t;

  typedef struct packed {
    bit         is_cfg;
    logic [1:0] idx;
    logic [9:0] cdata;
    logic       op;
    logic [9:0] ch;
    logic [7:0] val;
    bit         typed;
    sym_t       want;
  } row_t;

  logic       clk;
  logic       rst;
  logic       in_valid;
  logic       in_stall;
  logic       opcode;
  logic [9:0] channel;
  logic [7:0] value;
  logic       out_valid;
  logic       out_stall;
  logic [2:0] kind;
  logic [7:0] data;
  logic [9:0] duration_us;
  logic       last_slot;
  logic       cfg_we;
  logic [1:0] cfg_index;
  logic [9:0] cfg_data;

  dmx_double_buffered_transmitter #(
    .CHANNELS(CHANNELS)
  ) dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .opcode(opcode),
    .channel(channel),
    .value(value),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .kind(kind),
    .data(data),
    .duration_us(duration_us),
    .last_slot(last_slot),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  logic [7:0] level_mem [0:2*CHANNELS-1];
  logic       front_sel;
  logic       swap_due;
  int         sym_pos;
  int         frame_slots_r;
  int         break_us_r;
  int         mab_us_r;

  sym_t       symbols_due[$];
  sym_t       head;
  row_t       script[$];
  int         errors;
  int         cycles;
  int         send_gap_pct;
  int         recv_stall_pct;
  int         hold_left;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic int limit_to(input int v, input int lo, input int hi);
    if (v < lo) begin
      return lo;
    end
    if (v > hi) begin
      return hi;
    end
    return v;
  endfunction

  function automatic sym_t sym(input logic [2:0] k, input logic [7:0] d, input logic [9:0] du,
                               input logic l);
    sym_t s;
    s.kind = k;
    s.data = d;
    s.dur = du;
    s.last = l;
    return s;
  endfunction

  function automatic row_t adv(input bit chk, input sym_t want);
    row_t r;
    r = '0;
    r.op = OP_ADVANCE;
    r.typed = chk;
    r.want = want;
    return r;
  endfunction

  function automatic row_t wr(input logic [9:0] ch, input logic [7:0] v, input bit chk,
                              input sym_t want);
    row_t r;
    r = '0;
    r.op = OP_WRITE;
    r.ch = ch;
    r.val = v;
    r.typed = chk;
    r.want = want;
    return r;
  endfunction

  function automatic row_t reg_wr(input logic [1:0] i, input logic [9:0] d);
    row_t r;
    r = '0;
    r.is_cfg = 1'b1;
    r.idx = i;
    r.cdata = d;
    return r;
  endfunction

  task automatic step_universe(input logic op, input logic [9:0] ch, input logic [7:0] val,
                               output sym_t s);
    int k;
    int slots;
    s = '0;
    if (op == OP_WRITE) begin
      if (ch == 10'd0 || int'(ch) > CHANNELS) begin
        s.kind = KIND_WRITE_BAD;
      end else begin
        level_mem[(front_sel ? 0 : CHANNELS) + int'(ch) - 1] = val;
        swap_due = 1'b1;
        s.kind = KIND_WRITE_OK;
      end
    end else if (sym_pos == POS_BREAK) begin
      if (swap_due) begin
        front_sel = ~front_sel;
        swap_due = 1'b0;
      end
      sym_pos = POS_MAB;
      s.kind = KIND_BREAK;
      s.dur = 10'(limit_to(break_us_r, 88, 1000));
    end else if (sym_pos == POS_MAB) begin
      sym_pos = POS_FIRST_SLOT;
      s.kind = KIND_MAB;
      s.dur = 10'(limit_to(mab_us_r, 8, 1000));
    end else begin
      slots = limit_to(frame_slots_r, 1, CHANNELS + 1);
      k = sym_pos - POS_FIRST_SLOT;
      if (k >= 1 && k <= CHANNELS) begin
        s.data = level_mem[(front_sel ? CHANNELS : 0) + k - 1];
      end
      s.kind = KIND_SLOT;
      s.last = (k + 1 >= slots);
      sym_pos = s.last ? POS_BREAK : sym_pos + 1;
    end
  endtask

  // Called at a falling edge; returns at the falling edge after the word is taken.
  task automatic send_word(input logic op, input logic [9:0] ch, input logic [7:0] val,
                           input bit chk, input sym_t want);
    sym_t model_sym;
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    opcode <= op;
    channel <= ch;
    value <= val;
    @(posedge clk);
    while (in_stall) begin
      @(posedge clk);
    end
    step_universe(op, ch, val, model_sym);
    symbols_due.push_back(chk ? want : model_sym);
    @(negedge clk);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    do begin
      @(negedge clk);
    end while (symbols_due.size() != 0);
  endtask

  task automatic write_reg(input logic [1:0] i, input logic [9:0] d);
    cfg_we <= 1'b1;
    cfg_index <= i;
    cfg_data <= d;
    case (i)
      CFG_FRAME_SLOTS: frame_slots_r = d;
      CFG_BREAK_US: break_us_r = d;
      CFG_MAB_US: mab_us_r = d;
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  task automatic random_word();
    logic       op;
    logic [9:0] ch;
    int         pick;
    op = ($urandom_range(99) < 60) ? OP_ADVANCE : OP_WRITE;
    pick = $urandom_range(99);
    if (pick < 50) begin
      ch = 10'($urandom_range(1, 24));
    end else if (pick < 80) begin
      ch = 10'($urandom_range(1, CHANNELS));
    end else if (pick < 90) begin
      ch = $urandom_range(1) ? 10'd0 : 10'(CHANNELS);
    end else begin
      ch = 10'($urandom_range(CHANNELS + 1, 1023));
    end
    send_word(op, ch, 8'($urandom_range(255)), 1'b0, '0);
  endtask

  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left = hold_left - 1;
      end else begin
        out_stall <= ($urandom_range(99) < recv_stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("%0t: timed out with %0d words outstanding", $time, symbols_due.size());
      $display("FAIL dmx_double_buffered_transmitter");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (symbols_due.size() == 0) begin
        $display("%0t: unexpected word kind=%0d data=%0d dur=%0d last=%0d", $time, kind, data,
                 duration_us, last_slot);
        errors = errors + 1;
      end else begin
        head = symbols_due.pop_front();
        if (kind !== head.kind) begin
          $display("%0t: kind expected %0d actual %0d", $time, head.kind, kind);
          errors = errors + 1;
        end
        if (data !== head.data) begin
          $display("%0t: data expected %0d actual %0d", $time, head.data, data);
          errors = errors + 1;
        end
        if (duration_us !== head.dur) begin
          $display("%0t: duration_us expected %0d actual %0d", $time, head.dur, duration_us);
          errors = errors + 1;
        end
        if (last_slot !== head.last) begin
          $display("%0t: last_slot expected %0d actual %0d", $time, head.last, last_slot);
          errors = errors + 1;
        end
      end
    end
  end

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    opcode = OP_WRITE;
    channel = '0;
    value = '0;
    cfg_we = 1'b0;
    cfg_index = CFG_FRAME_SLOTS;
    cfg_data = '0;
    errors = 0;
    cycles = 0;
    send_gap_pct = 0;
    recv_stall_pct = 0;
    hold_left = 0;
    for (int i = 0; i < 2 * CHANNELS; i++) begin
      level_mem[i] = 8'd0;
    end
    front_sel = 1'b0;
    swap_due = 1'b0;
    sym_pos = POS_BREAK;
    frame_slots_r = RST_FRAME_SLOTS;
    break_us_r = RST_BREAK_US;
    mab_us_r = RST_MAB_US;

    script.push_back(adv(1'b1, sym(KIND_BREAK, 8'd0, 10'd184, 1'b0)));
    script.push_back(adv(1'b1, sym(KIND_MAB, 8'd0, 10'd24, 1'b0)));
    script.push_back(adv(1'b1, sym(KIND_SLOT, NULL_START_BYTE, 10'd0, 1'b0)));
    script.push_back(adv(1'b1, sym(KIND_SLOT, 8'd0, 10'd0, 1'b0)));
    script.push_back(wr(10'd0, 8'd7, 1'b1, sym(KIND_WRITE_BAD, 8'd0, 10'd0, 1'b0)));
    script.push_back(wr(10'd513, 8'd7, 1'b1, sym(KIND_WRITE_BAD, 8'd0, 10'd0, 1'b0)));
    script.push_back(wr(10'd1023, 8'd255, 1'b1, sym(KIND_WRITE_BAD, 8'd0, 10'd0, 1'b0)));
    script.push_back(wr(10'd1, 8'd255, 1'b1, sym(KIND_WRITE_OK, 8'd0, 10'd0, 1'b0)));
    script.push_back(wr(10'd512, 8'd0, 1'b1, sym(KIND_WRITE_OK, 8'd0, 10'd0, 1'b0)));
    script.push_back(wr(10'd2, 8'hA5, 1'b1, sym(KIND_WRITE_OK, 8'd0, 10'd0, 1'b0)));
    script.push_back(wr(10'd3, 8'h5A, 1'b0, '0));
    script.push_back(adv(1'b0, '0));
    script.push_back(adv(1'b0, '0));
    // Shrinking the frame mid-way ends it on the next slot.
    script.push_back(reg_wr(CFG_FRAME_SLOTS, 10'd3));
    script.push_back(adv(1'b0, '0));
    script.push_back(adv(1'b1, sym(KIND_BREAK, 8'd0, 10'd184, 1'b0)));
    script.push_back(adv(1'b1, sym(KIND_MAB, 8'd0, 10'd24, 1'b0)));
    script.push_back(adv(1'b1, sym(KIND_SLOT, NULL_START_BYTE, 10'd0, 1'b0)));
    script.push_back(adv(1'b1, sym(KIND_SLOT, 8'd255, 10'd0, 1'b0)));
    script.push_back(adv(1'b1, sym(KIND_SLOT, 8'hA5, 10'd0, 1'b1)));
    script.push_back(reg_wr(CFG_BREAK_US, 10'd1023));
    script.push_back(reg_wr(CFG_MAB_US, 10'd7));
    script.push_back(reg_wr(CFG_UNUSED, 10'd5));
    script.push_back(adv(1'b1, sym(KIND_BREAK, 8'd0, 10'd1000, 1'b0)));
    script.push_back(adv(1'b1, sym(KIND_MAB, 8'd0, 10'd8, 1'b0)));

    repeat (8) @(negedge clk);
    rst <= 1'b0;

    foreach (script[i]) begin
      if (script[i].is_cfg) begin
        settle();
        write_reg(script[i].idx, script[i].cdata);
      end else begin
        send_word(script[i].op, script[i].ch, script[i].val, script[i].typed, script[i].want);
      end
    end

    for (int p = 0; p < PHASES; p++) begin
      settle();
      case (p % 4)
        0: begin
          send_gap_pct = 0;
          recv_stall_pct = 0;
        end
        1: begin
          send_gap_pct = 76;
          recv_stall_pct = 0;
        end
        2: begin
          send_gap_pct = 0;
          recv_stall_pct = 76;
        end
        default: begin
          send_gap_pct = 16;
          recv_stall_pct = 16;
        end
      endcase
      case (p)
        0: begin
          write_reg(CFG_FRAME_SLOTS, 10'd4);
          write_reg(CFG_BREAK_US, 10'd88);
          write_reg(CFG_MAB_US, 10'd8);
        end
        1: begin
          write_reg(CFG_FRAME_SLOTS, 10'd1);
          write_reg(CFG_BREAK_US, 10'd1000);
          write_reg(CFG_MAB_US, 10'd1000);
        end
        2: begin
          write_reg(CFG_FRAME_SLOTS, 10'd0);
          write_reg(CFG_BREAK_US, 10'd87);
          write_reg(CFG_MAB_US, 10'd7);
        end
        3: begin
          write_reg(CFG_FRAME_SLOTS, 10'd513);
          write_reg(CFG_BREAK_US, 10'd1023);
          write_reg(CFG_MAB_US, 10'd1023);
        end
        4: begin
          write_reg(CFG_FRAME_SLOTS, 10'd1023);
          write_reg(CFG_BREAK_US, 10'($urandom_range(1023)));
          write_reg(CFG_MAB_US, 10'($urandom_range(1023)));
        end
        default: begin
          write_reg(CFG_FRAME_SLOTS, 10'($urandom_range(2, 24)));
          write_reg(CFG_BREAK_US, 10'($urandom_range(1023)));
          write_reg(CFG_MAB_US, 10'($urandom_range(1023)));
        end
      endcase
      // A long output hold lets the pipeline fill and push back on the input.
      if (p == 5) begin
        hold_left = 300;
      end
      repeat (WORDS_PER_PHASE) random_word();
    end

    settle();
    repeat (10) @(negedge clk);
    if (errors == 0) begin
      $display("PASS dmx_double_buffered_transmitter");
    end else begin
      $display("FAIL dmx_double_buffered_transmitter");
    end
    $finish;
  end

endmodule

### sim.f
rtl/core/dmxdbt_pkg.sv
rtl/core/dmxdbt_bank_ram.sv
rtl/core/dmxdbt_ctrl.sv
rtl/core/dmx_double_buffered_transmitter.sv
tb/tb_dmx_double_buffered_transmitter.sv
